>>> hdl/dqws_pkg.sv
// Shared types, constants and widths for the dual quadrature wheel-speed block.
`default_nettype none

package dqws_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_WIDTH = 32;
    localparam int SPEED_WIDTH = 32;
    // Signed count times unsigned scale, with one spare bit.
    localparam int PROD_WIDTH  = COUNT_WIDTH + SCALE_WIDTH + 1;

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    localparam int          ADDR_WIDTH        = 3;
    localparam logic        REG_SPEED_SCALE   = 1'b0;
    localparam logic [SCALE_WIDTH-1:0] SPEED_SCALE_RESET = 32'd65536;

    typedef struct packed {
        logic tick;
        logic left_b;
        logic left_a;
        logic right_b;
        logic right_a;
    } sample_t;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] right_total;
        logic signed [COUNT_WIDTH-1:0] left_total;
        logic signed [SPEED_WIDTH-1:0] right_speed;
        logic signed [SPEED_WIDTH-1:0] left_speed;
        logic signed [SPEED_WIDTH-1:0] mean_speed;
    } report_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic load_prod;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/dqws_lane.sv
// One wheel lane: x4 quadrature decode, saturating count, period latch and scale multiply.
`default_nettype none

module dqws_lane (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  dqws_pkg::lane_ctrl_t                      ctrl,
    input  logic                                      pin_a,
    input  logic                                      pin_b,
    input  logic [dqws_pkg::SCALE_WIDTH-1:0]          scale,
    output logic signed [dqws_pkg::COUNT_WIDTH-1:0]   total,
    output logic signed [dqws_pkg::PROD_WIDTH-1:0]    product
);

    localparam int CW = dqws_pkg::COUNT_WIDTH;

    logic [1:0]                                pins_reg;
    logic signed [CW-1:0]                      count_reg;
    logic signed [CW-1:0]                      count_next;
    logic signed [CW-1:0]                      stepped;
    logic signed [CW-1:0]                      hold_reg;
    logic signed [CW-1:0]                      total_reg;
    logic signed [dqws_pkg::PROD_WIDTH-1:0]    product_reg;
    logic                                      a_edge;
    logic                                      b_edge;
    logic                                      same;
    logic                                      step_up;
    logic                                      step_dn;

    always_comb
    begin
        a_edge  = pins_reg[0] ^ pin_a;
        b_edge  = pins_reg[1] ^ pin_b;
        same    = (pin_a == pin_b);
        step_up = (a_edge && !same) || (b_edge && same);
        step_dn = (a_edge && same) || (b_edge && !same);
        stepped = count_reg;
        // When both pins move, one edge counts up and the other down.
        if (step_up && !step_dn && count_reg != dqws_pkg::COUNT_MAX)
        begin
            stepped = count_reg + CW'(1);
        end
        else if (step_dn && !step_up && count_reg != dqws_pkg::COUNT_MIN)
        begin
            stepped = count_reg - CW'(1);
        end
        count_next = ctrl.tick ? '0 : stepped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            pins_reg  <= {pin_b, pin_a};
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && ctrl.tick)
        begin
            hold_reg <= stepped;
        end
        if (ctrl.load_prod)
        begin
            total_reg   <= hold_reg;
            product_reg <= $signed(hold_reg) * $signed({1'b0, scale});
        end
    end

    assign total   = total_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

>>> hdl/dqws_merge.sv
// Merge stage: scales both products to speeds, saturates, averages and holds the report.
`default_nettype none

module dqws_merge (
    input  logic                                    clk,
    input  logic                                    load,
    input  logic signed [dqws_pkg::COUNT_WIDTH-1:0] right_total,
    input  logic signed [dqws_pkg::COUNT_WIDTH-1:0] left_total,
    input  logic signed [dqws_pkg::PROD_WIDTH-1:0]  right_product,
    input  logic signed [dqws_pkg::PROD_WIDTH-1:0]  left_product,
    output dqws_pkg::report_t                       report
);

    localparam int PW = dqws_pkg::PROD_WIDTH;
    localparam int SW = dqws_pkg::SPEED_WIDTH;

    dqws_pkg::report_t       report_reg;
    dqws_pkg::report_t       report_next;
    logic signed [SW:0]      sum;

    // Floor shift by the fraction bits, then clamp to the signed speed range.
    function automatic logic signed [SW-1:0] to_speed(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic [PW-SW:0]       hi;
        begin
            s  = p >>> dqws_pkg::FRAC_BITS;
            hi = s[PW-1:SW-1];
            if ((&hi) || !(|hi))
            begin
                to_speed = s[SW-1:0];
            end
            else if (s[PW-1])
            begin
                to_speed = {1'b1, {(SW-1){1'b0}}};
            end
            else
            begin
                to_speed = {1'b0, {(SW-1){1'b1}}};
            end
        end
    endfunction

    always_comb
    begin
        report_next.right_total = right_total;
        report_next.left_total  = left_total;
        report_next.right_speed = to_speed(right_product);
        report_next.left_speed  = to_speed(left_product);
        sum = {report_next.right_speed[SW-1], report_next.right_speed}
            + {report_next.left_speed[SW-1], report_next.left_speed};
        report_next.mean_speed  = sum[SW:1];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            report_reg <= report_next;
        end
    end

    assign report = report_reg;

endmodule

`default_nettype wire

>>> hdl/dual_quadrature_wheel_speed.sv
// Top level of the dual quadrature wheel-speed block: handshakes, register port, lanes, merge.
//
// The block takes one sample word per clock: the A and B levels of the right and left
// encoders and a tick bit. Each lane decodes its encoder at four counts per line cycle
// and keeps a saturating signed count. A word with tick set closes the period; its report
// word (both totals, both speeds and their mean) then passes through the latch, multiply
// and report registers in turn once that word is accepted. Words without tick produce no
// report. Sample_ready falls only when the latch, multiply and report registers all hold
// periods behind a stalled report; otherwise the block takes a word every cycle.
// Speed_scale sits at byte address 0 of the register port.
`default_nettype none

module dual_quadrature_wheel_speed (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dqws_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  dqws_pkg::sample_t                     sample,
    output logic                                  report_valid,
    input  logic                                  report_ready,
    output dqws_pkg::report_t                     report
);

    logic [dqws_pkg::SCALE_WIDTH-1:0]          scale_reg;
    logic                                      hold_valid_reg;
    logic                                      hold_valid_next;
    logic                                      prod_valid_reg;
    logic                                      prod_valid_next;
    logic                                      out_valid_reg;
    logic                                      out_valid_next;
    logic                                      out_free;
    logic                                      prod_ready;
    logic                                      load_out;
    logic                                      accept;
    dqws_pkg::lane_ctrl_t                      ctrl;
    logic signed [dqws_pkg::COUNT_WIDTH-1:0]   right_total;
    logic signed [dqws_pkg::COUNT_WIDTH-1:0]   left_total;
    logic signed [dqws_pkg::PROD_WIDTH-1:0]    right_product;
    logic signed [dqws_pkg::PROD_WIDTH-1:0]    left_product;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dqws_pkg::REG_SPEED_SCALE) ? scale_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= dqws_pkg::SPEED_SCALE_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == dqws_pkg::REG_SPEED_SCALE)
        begin
            scale_reg <= pwdata;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || report_ready;
        load_out       = prod_valid_reg && out_free;
        prod_ready     = !prod_valid_reg || out_free;
        sample_ready   = !hold_valid_reg || prod_ready;
        accept         = sample_valid && sample_ready;
        ctrl.accept    = accept;
        ctrl.tick      = sample.tick;
        ctrl.load_prod = hold_valid_reg && prod_ready;

        hold_valid_next = hold_valid_reg;
        if (accept && sample.tick)
        begin
            hold_valid_next = 1'b1;
        end
        else if (ctrl.load_prod)
        begin
            hold_valid_next = 1'b0;
        end

        prod_valid_next = prod_valid_reg;
        if (ctrl.load_prod)
        begin
            prod_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            prod_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (report_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    dqws_lane u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pin_a   (sample.right_a),
        .pin_b   (sample.right_b),
        .scale   (scale_reg),
        .total   (right_total),
        .product (right_product)
    );

    dqws_lane u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pin_a   (sample.left_a),
        .pin_b   (sample.left_b),
        .scale   (scale_reg),
        .total   (left_total),
        .product (left_product)
    );

    dqws_merge u_merge (
        .clk           (clk),
        .load          (load_out),
        .right_total   (right_total),
        .left_total    (left_total),
        .right_product (right_product),
        .left_product  (left_product),
        .report        (report)
    );

    assign report_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/dqws_checker.sv
// Port-level checker for the dual quadrature wheel-speed block, bound to the top level.
`default_nettype none

module dqws_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    input  logic              report_ready,
    input  dqws_pkg::report_t report
);

    // A stalled report word must hold.
    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(report))
        else $error("report word changed while stalled");

    // The mean of two speeds lies between them.
    a_mean_between: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> !(report.mean_speed > report.right_speed
                           && report.mean_speed > report.left_speed)
                      && !(report.mean_speed < report.right_speed
                           && report.mean_speed < report.left_speed))
        else $error("mean speed outside the two wheel speeds");

    // A wheel with no net count has no speed.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report.right_total == 0 && report.left_total == 0
        |-> report.right_speed == 0 && report.left_speed == 0 && report.mean_speed == 0)
        else $error("speed nonzero for zero count");

    // The scale is unsigned, so a speed never has the opposite sign of its count.
    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> !(report.right_total > 0 && report.right_speed < 0)
                      && !(report.right_total < 0 && report.right_speed > 0)
                      && !(report.left_total > 0 && report.left_speed < 0)
                      && !(report.left_total < 0 && report.left_speed > 0))
        else $error("speed sign opposite to count sign");

endmodule

bind dual_quadrature_wheel_speed dqws_checker u_dqws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
);

`default_nettype wire
